// ===== rtl/core/fvom_pkg.sv =====
package fvom_pkg;

    // input beat commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // voice register select
    localparam logic [1:0] REG_FREQ   = 2'd0;
    localparam logic [1:0] REG_DUTY   = 2'd1;
    localparam logic [1:0] REG_VOLUME = 2'd2;
    localparam logic [1:0] REG_WAVE   = 2'd3;

    // waveform codes, anything else is silent
    localparam logic [2:0] WAVE_TRI   = 3'd0;
    localparam logic [2:0] WAVE_SAW   = 3'd1;
    localparam logic [2:0] WAVE_PULSE = 3'd2;
    localparam logic [2:0] WAVE_NOISE = 3'd3;

    // 6-bit signed level times 8-bit unsigned volume
    localparam int PROD_W = 15;

    localparam logic [31:0] LFSR_SEED = 32'd1;

    typedef struct packed {
        logic [15:0] duty;
        logic [7:0]  volume;
        logic [2:0]  wave;
    } t_voice_cfg;

endpackage

// ===== rtl/core/fvom_voice.sv =====
module fvom_voice (
    input  logic [15:0]                       i_phase,
    input  fvom_pkg::t_voice_cfg              i_cfg,
    input  logic [5:0]                        i_noise,
    output logic signed [fvom_pkg::PROD_W-1:0] o_level
);

    logic [5:0] w_raw;

    // 6-bit results wrap into two's complement in [-32,31]
    always_comb begin
        case (i_cfg.wave)
            fvom_pkg::WAVE_TRI: begin
                if (!i_phase[15]) begin
                    w_raw = i_phase[14:9] - 6'd32;
                end else begin
                    w_raw = 6'd31 - i_phase[14:9];
                end
            end
            fvom_pkg::WAVE_SAW: begin
                w_raw = i_phase[15:10] - 6'd32;
            end
            fvom_pkg::WAVE_PULSE: begin
                w_raw = (i_phase > i_cfg.duty) ? 6'h20 : 6'd31;
            end
            fvom_pkg::WAVE_NOISE: begin
                w_raw = i_noise - 6'd32;
            end
            default: begin
                w_raw = 6'd0;
            end
        endcase
    end

    assign o_level = fvom_pkg::PROD_W'($signed(w_raw))
                   * fvom_pkg::PROD_W'($signed({1'b0, i_cfg.volume}));

endmodule

// ===== rtl/core/four_voice_oscillator_mixer_top.sv =====
// four-voice oscillator mixer
//
// input channel (i_valid / o_stall): each beat is either a voice register
// write (i_command low: i_voice, i_reg_select, i_value) or a sample tick
// (i_command high). writes give no output beat; every tick gives one
// o_sample beat on the output channel (o_valid / i_stall).
// an accepted beat is held in the input register and worked on from there; a
// tick's sample is then written to the output register, which drives o_valid.
// one beat is taken per cycle while o_stall is low, with the voices computed
// side by side in one pass between the input and output registers.
// while the receiver stalls, the held sample stays put and only a tick that
// is waiting behind it raises o_stall; writes keep flowing.
// reset clears all phases, steps, duties, volumes and waveform codes to zero,
// seeds the noise register with one and empties both registers.
// voice numbers at or above NUM_VOICES are ignored on write.
module four_voice_oscillator_mixer_top #(
    parameter int NUM_VOICES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [1:0]  i_voice,
    input  logic [1:0]  i_reg_select,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_sample
);

    localparam int SUM_W = fvom_pkg::PROD_W + 1 + $clog2(NUM_VOICES);

    logic        r_in_valid;
    logic        r_in_command;
    logic [1:0]  r_in_voice;
    logic [1:0]  r_in_reg_select;
    logic [15:0] r_in_value;

    logic [15:0]          r_phase [NUM_VOICES];
    logic [15:0]          r_freq  [NUM_VOICES];
    fvom_pkg::t_voice_cfg r_cfg   [NUM_VOICES];
    logic [31:0]          r_lfsr;
    logic [31:0]          n_lfsr;

    logic       r_out_valid;
    logic [7:0] r_out_sample;
    logic [7:0] n_out_sample;

    logic w_blocked;
    logic w_fire;
    logic w_tick;
    logic w_write;

    logic signed [fvom_pkg::PROD_W-1:0] w_prod [NUM_VOICES];
    logic signed [SUM_W-1:0]            w_sum;
    logic signed [SUM_W-1:0]            w_level;

    // a tick can only move on if the output register is free or draining
    assign w_blocked = r_in_valid && (r_in_command == fvom_pkg::CMD_TICK)
                       && r_out_valid && i_stall;
    assign w_fire    = r_in_valid && !w_blocked;
    assign w_tick    = w_fire && (r_in_command == fvom_pkg::CMD_TICK);
    assign w_write   = w_fire && (r_in_command == fvom_pkg::CMD_WRITE);
    assign o_stall   = w_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_command    <= i_command;
            r_in_voice      <= i_voice;
            r_in_reg_select <= i_reg_select;
            r_in_value      <= i_value;
        end
    end

    // shift first, noise voices see the new low bits
    assign n_lfsr = {r_lfsr[30:0], r_lfsr[31] ^ r_lfsr[24] ^ r_lfsr[9] ^ r_lfsr[6]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= fvom_pkg::LFSR_SEED;
        end else if (w_tick) begin
            r_lfsr <= n_lfsr;
        end
    end

    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_phase[v] <= '0;
                r_freq[v]  <= '0;
                r_cfg[v]   <= '0;
            end else begin
                if (w_tick) begin
                    r_phase[v] <= r_phase[v] + r_freq[v];
                end
                if (w_write && ({30'd0, r_in_voice} == 32'(v))) begin
                    case (r_in_reg_select)
                        fvom_pkg::REG_FREQ:   r_freq[v]        <= r_in_value;
                        fvom_pkg::REG_DUTY:   r_cfg[v].duty    <= r_in_value;
                        fvom_pkg::REG_VOLUME: r_cfg[v].volume  <= r_in_value[7:0];
                        default:              r_cfg[v].wave    <= r_in_value[2:0];
                    endcase
                end
            end
        end

        fvom_voice u_voice (
            .i_phase (r_phase[v]),
            .i_cfg   (r_cfg[v]),
            .i_noise (n_lfsr[5:0]),
            .o_level (w_prod[v])
        );
    end

    always_comb begin
        w_sum = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            w_sum = w_sum + SUM_W'(w_prod[v]);
        end
    end

    // floor divide by 256 and recentre, clamped to a byte
    assign w_level = (w_sum >>> 8) + SUM_W'(128);

    always_comb begin
        if (w_level < SUM_W'(0)) begin
            n_out_sample = 8'd0;
        end else if (w_level > SUM_W'(255)) begin
            n_out_sample = 8'hFF;
        end else begin
            n_out_sample = w_level[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out_sample <= n_out_sample;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

`ifndef SYNTHESIS
    a_tick_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> o_valid)
        else $error("processed tick did not produce an output beat");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 32'd0)
        else $error("noise register reached zero");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && (r_in_command == fvom_pkg::CMD_TICK) && r_out_valid))
        else $error("input stalled without a tick waiting on a full output");

    a_write_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && !o_valid) |=> !o_valid)
        else $error("register write produced an output beat");
`endif

endmodule
